@@ hw/rtl/pbu_pkg.sv @@
// Shared types, register map and arithmetic constants of the pixel blend unit.
package pbu_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register word indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_BLEND_MODE   = 3'd0;
  localparam logic [2:0] REG_CHANNEL_PICK = 3'd1;
  localparam logic [2:0] REG_PARAM_BLUE   = 3'd2;
  localparam logic [2:0] REG_PARAM_GREEN  = 3'd3;
  localparam logic [2:0] REG_PARAM_RED    = 3'd4;

  localparam logic [1:0] PICK_BLUE  = 2'd0;
  localparam logic [1:0] PICK_GREEN = 2'd1;

  // floor(y / 255) == (y * Div255Recip) >> Div255Shift for every y below 2^18.
  localparam int unsigned Div255Recip = 263173;
  localparam int unsigned Div255Shift = 26;
  localparam int unsigned DivRound    = 127;

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_SUBTRACT = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_SCALE    = 3'd5,
    MODE_COPY     = 3'd6
  } mode_e;

  // How the second lane stage finishes a channel.
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_DIV    = 2'd1,
    KIND_CLAMP  = 2'd2
  } kind_e;

  typedef struct packed {
    mode_e             mode;
    logic [1:0]        pick;
    logic signed [8:0] param_blue;
    logic signed [8:0] param_green;
    logic signed [8:0] param_red;
  } cfg_t;

endpackage

@@ hw/rtl/pbu_if.sv @@
// Valid/ready channel interfaces for the pixel pair input and the blended pixel output.
interface pbu_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] a_blue;
  logic [7:0] a_green;
  logic [7:0] a_red;
  logic [7:0] b_blue;
  logic [7:0] b_green;
  logic [7:0] b_red;

  modport source (
    output valid, a_blue, a_green, a_red, b_blue, b_green, b_red,
    input  ready
  );
  modport sink (
    input  valid, a_blue, a_green, a_red, b_blue, b_green, b_red,
    output ready
  );
endinterface

interface pbu_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;

  modport source (
    output valid, out_blue, out_green, out_red,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red,
    output ready
  );
endinterface

@@ hw/rtl/pbu_cfg.sv @@
// APB register file holding the blend mode, channel pick and per-channel parameters.
module pbu_cfg import pbu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BLEND_MODE:   cfg_d.mode        = mode_e'(pwdata[2:0]);
        REG_CHANNEL_PICK: cfg_d.pick        = pwdata[1:0];
        REG_PARAM_BLUE:   cfg_d.param_blue  = $signed(pwdata[8:0]);
        REG_PARAM_GREEN:  cfg_d.param_green = $signed(pwdata[8:0]);
        REG_PARAM_RED:    cfg_d.param_red   = $signed(pwdata[8:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_MULTIPLY, pick: PICK_BLUE,
                 param_blue: '0, param_green: '0, param_red: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLEND_MODE:   prdata = {29'd0, cfg_q.mode};
      REG_CHANNEL_PICK: prdata = {30'd0, cfg_q.pick};
      REG_PARAM_BLUE:   prdata = {{23{cfg_q.param_blue[8]}}, cfg_q.param_blue};
      REG_PARAM_GREEN:  prdata = {{23{cfg_q.param_green[8]}}, cfg_q.param_green};
      REG_PARAM_RED:    prdata = {{23{cfg_q.param_red[8]}}, cfg_q.param_red};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/pbu_lane.sv @@
// One color channel: operand setup and multiply, then divide-by-255 rounding, clamping or a direct result.
module pbu_lane import pbu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  mode_e             mode_i,
  input  logic [7:0]        a_i,
  input  logic [7:0]        b_i,
  input  logic signed [8:0] param_i,
  output logic [7:0]        res_o
);

  logic [7:0]         mul_x;
  logic signed [10:0] mul_y;
  logic signed [19:0] mul_full;
  logic signed [10:0] add_sum;
  kind_e              kind_d, kind_q;
  logic               inv_d, inv_q;
  logic [7:0]         direct_d, direct_q;
  logic signed [18:0] prod_q;

  logic [17:0] div_in;
  logic [36:0] recip;
  logic [7:0]  quot;

  assign add_sum  = $signed({3'd0, a_i}) + {{2{param_i[8]}}, param_i};
  assign mul_full = $signed({1'b0, mul_x}) * mul_y;

  always_comb begin
    mul_x    = a_i;
    mul_y    = '0;
    kind_d   = KIND_DIRECT;
    inv_d    = 1'b0;
    direct_d = '0;
    case (mode_i)
      MODE_MULTIPLY: begin
        mul_y  = $signed({3'd0, b_i});
        kind_d = KIND_DIV;
      end
      MODE_SCREEN: begin
        mul_x  = ~a_i;
        mul_y  = $signed({3'd0, ~b_i});
        kind_d = KIND_DIV;
        inv_d  = 1'b1;
      end
      MODE_SUBTRACT: begin
        direct_d = (b_i >= a_i) ? (b_i - a_i) : 8'd0;
      end
      MODE_OVERLAY: begin
        kind_d = KIND_DIV;
        if (!b_i[7]) begin
          mul_y = $signed({2'd0, b_i, 1'b0});
        end else begin
          mul_x = ~a_i;
          mul_y = $signed({2'd0, ~b_i, 1'b0});
          inv_d = 1'b1;
        end
      end
      MODE_ADD: begin
        if (add_sum[10]) begin
          direct_d = 8'd0;
        end else if (|add_sum[9:8]) begin
          direct_d = 8'hFF;
        end else begin
          direct_d = add_sum[7:0];
        end
      end
      MODE_SCALE: begin
        mul_y  = {{2{param_i[8]}}, param_i};
        kind_d = KIND_CLAMP;
      end
      MODE_COPY: begin
        direct_d = a_i;
      end
      default: begin
        direct_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= mul_full[18:0];
      kind_q   <= kind_d;
      inv_q    <= inv_d;
      direct_q <= direct_d;
    end
  end

  // Rounded divide by 255: add half the divisor, then multiply by the reciprocal.
  assign div_in = prod_q[17:0] + 18'(DivRound);
  assign recip  = 37'(div_in) * 37'(Div255Recip);
  assign quot   = recip[Div255Shift +: 8];

  always_comb begin
    case (kind_q)
      KIND_DIV:   res_o = inv_q ? ~quot : quot;
      KIND_CLAMP: begin
        if (prod_q[18]) begin
          res_o = 8'd0;
        end else if (|prod_q[17:8]) begin
          res_o = 8'hFF;
        end else begin
          res_o = prod_q[7:0];
        end
      end
      default:    res_o = direct_q;
    endcase
  end

endmodule

@@ hw/rtl/pbu_merge.sv @@
// Combines the three lane results, applies channel copy and holds the output register.
module pbu_merge import pbu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          s1_valid_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    red_i,
  output logic          adv_o,
  pbu_pix_out_if.source pix_o
);

  logic       out_v_q, out_v_d;
  logic [7:0] blue_d, green_d, red_d;
  logic [7:0] blue_q, green_q, red_q;
  logic [7:0] pick_val;
  logic       load;

  // The output register frees up when empty or when its beat is taken.
  assign adv_o = !out_v_q || pix_o.ready;
  assign load  = adv_o && s1_valid_i;

  always_comb begin
    case (cfg_i.pick)
      PICK_BLUE:  pick_val = blue_i;
      PICK_GREEN: pick_val = green_i;
      default:    pick_val = red_i;
    endcase
  end

  always_comb begin
    if (cfg_i.mode == MODE_COPY) begin
      blue_d  = pick_val;
      green_d = pick_val;
      red_d   = pick_val;
    end else begin
      blue_d  = blue_i;
      green_d = green_i;
      red_d   = red_i;
    end
  end

  assign out_v_d = adv_o ? s1_valid_i : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
    end
  end

  assign pix_o.valid     = out_v_q;
  assign pix_o.out_blue  = blue_q;
  assign pix_o.out_green = green_q;
  assign pix_o.out_red   = red_q;

endmodule

@@ hw/rtl/pixel_blend_unit.sv @@
// Pixel blend unit top level: register file, three channel lanes and the merge stage.
//
// A top pixel A and a bottom pixel B arrive together as one beat on pix_i;
// the blended pixel leaves as one beat on pix_o. Both channels use valid and
// ready, and a beat moves on a clock edge where both are high.
// The blend mode, channel pick and the three per-channel parameters are set
// through the APB port; they must only be changed while no beat is in flight.
// Each beat passes through the lane stage and then the output register: the
// lane stage holds the product of one 11-by-9 multiplier per channel, or its
// direct result, and the output register holds the finished pixel after the
// divide-by-255 reciprocal multiply. pix_o.valid rises once the beat moves
// from the lane stage into the output register.
// Throughput is one pixel per clock; a new beat is accepted every cycle while
// the output register is free or being drained.
// When the receiver stalls, the finished pixel waits in the output register,
// one more pixel may still be accepted into the lane stage, and pix_i.ready
// drops only once both stages are full.
// Reset clears both stage valid flags and sets every configuration register
// to zero, which selects multiply mode.
module pixel_blend_unit import pbu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pbu_pix_in_if.sink       pix_i,
  pbu_pix_out_if.source    pix_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       s1_v_q, s1_v_d;
  logic       adv;
  logic       accept;
  logic [7:0] res_blue, res_green, res_red;

  pbu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign pix_i.ready = !s1_v_q || adv;
  assign accept      = pix_i.valid && pix_i.ready;
  assign s1_v_d      = pix_i.ready ? pix_i.valid : s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  pbu_lane u_lane_blue (
    .clk_i   (clk_i),
    .en_i    (accept),
    .mode_i  (cfg.mode),
    .a_i     (pix_i.a_blue),
    .b_i     (pix_i.b_blue),
    .param_i (cfg.param_blue),
    .res_o   (res_blue)
  );

  pbu_lane u_lane_green (
    .clk_i   (clk_i),
    .en_i    (accept),
    .mode_i  (cfg.mode),
    .a_i     (pix_i.a_green),
    .b_i     (pix_i.b_green),
    .param_i (cfg.param_green),
    .res_o   (res_green)
  );

  pbu_lane u_lane_red (
    .clk_i   (clk_i),
    .en_i    (accept),
    .mode_i  (cfg.mode),
    .a_i     (pix_i.a_red),
    .b_i     (pix_i.b_red),
    .param_i (cfg.param_red),
    .res_o   (res_red)
  );

  pbu_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_v_q),
    .blue_i     (res_blue),
    .green_i    (res_green),
    .red_i      (res_red),
    .adv_o      (adv),
    .pix_o      (pix_o)
  );

endmodule
